// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every clock edge outside reset
`define ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// property checked at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`else

`define ASSERT_RST(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== sv/cpc_pkg.sv =====
`default_nettype none

package cpc_pkg;

  localparam int PACKET_BYTES   = 32;
  localparam int RESPONSE_BYTES = 64;
  localparam int BRIGHT_LEVELS  = 50;

  localparam int POS_W  = $clog2(PACKET_BYTES);
  localparam int RIDX_W = $clog2(RESPONSE_BYTES);
  localparam int LVL_W  = $clog2(BRIGHT_LEVELS + 1);

  // packet positions of the command bytes
  localparam int POS_BUTTON  = 3;
  localparam int POS_MOTOR   = 5;
  localparam int POS_CHANNEL = 16;
  localparam int POS_LED1    = 20;
  localparam int POS_LED2    = 21;

  // response byte positions
  localparam int RESP_STATUS    = 41;
  localparam int RESP_RGB       = 42;
  localparam int RESP_MAIN      = 43;
  localparam int RESP_SIDE      = 44;
  localparam int RESP_ANGLE_HI  = 54;
  localparam int RESP_ANGLE_LO  = 55;

  // channel byte codes
  localparam logic [7:0] CHAN_RGB  = 8'h01;
  localparam logic [7:0] CHAN_MAIN = 8'h02;
  localparam logic [7:0] CHAN_SIDE = 8'h05;

  // button byte bits
  localparam int BTN_AUX   = 0;
  localparam int BTN_LASER = 1;
  localparam int BTN_UP    = 4;
  localparam int BTN_DOWN  = 6;

  // motor byte bits
  localparam int MOT1_OPEN  = 0;
  localparam int MOT2_LEFT  = 1;
  localparam int MOT1_CLOSE = 2;
  localparam int MOT2_RIGHT = 3;

  // reset values of the configuration registers
  localparam logic [7:0] MOTOR_DUTY_RESET    = 8'd150;
  localparam logic [7:0] HEADER_FIRST_RESET  = 8'h96;
  localparam logic [7:0] HEADER_SECOND_RESET = 8'hAA;
  localparam logic [7:0] HEADER_THIRD_RESET  = 8'hBE;

  // packet queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // duty = target * level / BRIGHT_LEVELS by reciprocal and one correction
  localparam int PROD_W      = 8 + LVL_W;
  localparam int RECIP_SHIFT = PROD_W + 6;
  localparam int RECIP       = (2 ** RECIP_SHIFT + BRIGHT_LEVELS - 1) / BRIGHT_LEVELS;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  typedef enum logic [1:0] {
    REG_MOTOR_DUTY    = 2'd0,
    REG_HEADER_FIRST  = 2'd1,
    REG_HEADER_SECOND = 2'd2,
    REG_HEADER_THIRD  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MOTOR_BRAKE   = 2'd0,
    MOTOR_FORWARD = 2'd1,
    MOTOR_REVERSE = 2'd2
  } motor_dir_t;

  typedef logic [LVL_W-1:0] level_t;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] header_third;
  } header_cfg_t;

  // command fields of one completed packet
  typedef struct packed {
    logic [7:0]       button_byte;
    logic [7:0]       motor_byte;
    logic [7:0]       channel_byte;
    logic [7:0]       new_led1;
    logic [7:0]       new_led2;
    logic signed [8:0] angle;
  } packet_t;

  function automatic level_t adjust_level(level_t level, logic [7:0] buttons);
    logic up;
    logic down;
    level_t result;
    up     = buttons[BTN_UP];
    down   = buttons[BTN_DOWN];
    result = level;
    if (up && down) begin
      result = (level != '0) ? '0 : LVL_W'(BRIGHT_LEVELS);
    end else if (up && level < LVL_W'(BRIGHT_LEVELS)) begin
      result = level + 1'b1;
    end else if (down && level != '0) begin
      result = level - 1'b1;
    end
    return result;
  endfunction

  // small table: level in percent, floored
  function automatic logic [7:0] level_percent(level_t level);
    logic [7:0] result;
    int         i;
    int         pct;
    result = '0;
    for (i = 0; i < 2 ** LVL_W; i++) begin
      pct = i * 100 / BRIGHT_LEVELS;
      if (level == LVL_W'(i)) result = pct[7:0];
    end
    return result;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cpc_front.sv =====
`default_nettype none

module cpc_front (
  input  wire                  clk,
  input  wire                  rst,
  input  cpc_pkg::header_cfg_t hdr,
  input  wire                  accept,
  input  wire [7:0]            rx_byte,
  input  wire signed [8:0]     tilt_angle,
  output logic                 pkt_push,
  output cpc_pkg::packet_t     pkt
);

  logic [cpc_pkg::POS_W-1:0] byte_position;
  logic [cpc_pkg::POS_W-1:0] byte_position_next;
  logic [7:0] button_byte, motor_byte, channel_byte, new_led1, new_led2;
  logic [7:0] button_next, motor_next, channel_next, led1_next, led2_next;
  logic       at_last;

  assign at_last = (byte_position == cpc_pkg::POS_W'(cpc_pkg::PACKET_BYTES - 1));

  // captures as they stand after this transfer, so the final byte counts too
  always_comb begin
    button_next  = button_byte;
    motor_next   = motor_byte;
    channel_next = channel_byte;
    led1_next    = new_led1;
    led2_next    = new_led2;
    if (accept) begin
      case (byte_position)
        cpc_pkg::POS_W'(cpc_pkg::POS_BUTTON):  button_next  = rx_byte;
        cpc_pkg::POS_W'(cpc_pkg::POS_MOTOR):   motor_next   = rx_byte;
        cpc_pkg::POS_W'(cpc_pkg::POS_CHANNEL): channel_next = rx_byte;
        cpc_pkg::POS_W'(cpc_pkg::POS_LED1):    led1_next    = rx_byte;
        cpc_pkg::POS_W'(cpc_pkg::POS_LED2):    led2_next    = rx_byte;
        default: ;
      endcase
    end
  end

  always_comb begin
    byte_position_next = byte_position;
    if (accept) begin
      case (byte_position)
        cpc_pkg::POS_W'(0): begin
          if (rx_byte == hdr.header_first) byte_position_next = cpc_pkg::POS_W'(1);
        end
        cpc_pkg::POS_W'(1): begin
          byte_position_next = (rx_byte == hdr.header_second) ? cpc_pkg::POS_W'(2) : '0;
        end
        cpc_pkg::POS_W'(2): begin
          byte_position_next = (rx_byte == hdr.header_third) ? cpc_pkg::POS_W'(3) : '0;
        end
        default: begin
          byte_position_next = at_last ? '0 : byte_position + 1'b1;
        end
      endcase
    end
  end

  assign pkt_push         = accept && at_last;
  assign pkt.button_byte  = button_next;
  assign pkt.motor_byte   = motor_next;
  assign pkt.channel_byte = channel_next;
  assign pkt.new_led1     = led1_next;
  assign pkt.new_led2     = led2_next;
  assign pkt.angle        = tilt_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else begin
      byte_position <= byte_position_next;
    end
    button_byte  <= button_next;
    motor_byte   <= motor_next;
    channel_byte <= channel_next;
    new_led1     <= led1_next;
    new_led2     <= led2_next;
  end

endmodule

`default_nettype wire

// ===== sv/cpc_queue.sv =====
`default_nettype none

module cpc_queue (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  cpc_pkg::packet_t push_pkt,
  output logic             full,
  input  wire              pop,
  output cpc_pkg::packet_t pop_pkt,
  output logic             empty
);

  cpc_pkg::packet_t           slots [cpc_pkg::QUEUE_DEPTH];
  logic [cpc_pkg::QPTR_W-1:0] wr_ptr;
  logic [cpc_pkg::QPTR_W-1:0] rd_ptr;
  logic [cpc_pkg::QCNT_W-1:0] count;
  logic                       do_push;
  logic                       do_pop;

  assign full    = (count == cpc_pkg::QCNT_W'(cpc_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_pkt = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == cpc_pkg::QPTR_W'(cpc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == cpc_pkg::QPTR_W'(cpc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
    if (do_push) begin
      slots[wr_ptr] <= push_pkt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cpc_back.sv =====
`default_nettype none

module cpc_back (
  input  wire              clk,
  input  wire              rst,
  input  cpc_pkg::packet_t pkt,
  input  wire              pkt_empty,
  output logic             pkt_pop,
  output logic             empty,
  input  wire              pop,
  output logic [7:0]       tx_byte,
  output logic             tx_last,
  output logic [7:0]       led1_duty,
  output logic [7:0]       led2_duty,
  output logic             laser_enable,
  output logic             aux_enable,
  output logic [1:0]       motor1_direction,
  output logic [1:0]       motor2_direction
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_SEND
  } state_t;

  localparam int EST_FULL_W = cpc_pkg::PROD_W + cpc_pkg::RECIP_W;
  localparam int CHK_W      = cpc_pkg::PROD_W + cpc_pkg::LVL_W;

  state_t                     state;
  logic [cpc_pkg::RIDX_W-1:0] resp_idx;
  logic [7:0]                 led1_target, led2_target;
  cpc_pkg::level_t            main_level, rgb_level, side_level;
  logic                       laser_state, aux_state;
  logic                       last_laser_button, last_aux_button;
  cpc_pkg::motor_dir_t        motor1_state, motor2_state;
  logic signed [8:0]          latched_angle;
  logic [cpc_pkg::PROD_W-1:0] prod1, prod2;
  logic [cpc_pkg::PROD_W-1:0] est1, est2;
  logic [EST_FULL_W-1:0]      est1_full, est2_full;
  logic [CHK_W-1:0]           chk1, chk2;
  logic [cpc_pkg::PROD_W-1:0] duty1_fix, duty2_fix;
  logic                       aux_btn, laser_btn;
  logic                       out_pop;

  assign pkt_pop   = (state == ST_IDLE) && !pkt_empty;
  assign empty     = (state != ST_SEND);
  assign out_pop   = pop && !empty;
  assign aux_btn   = pkt.button_byte[cpc_pkg::BTN_AUX];
  assign laser_btn = pkt.button_byte[cpc_pkg::BTN_LASER];

  assign est1_full = EST_FULL_W'(prod1) * EST_FULL_W'(cpc_pkg::RECIP);
  assign est2_full = EST_FULL_W'(prod2) * EST_FULL_W'(cpc_pkg::RECIP);
  assign chk1      = CHK_W'(est1) * CHK_W'(cpc_pkg::BRIGHT_LEVELS);
  assign chk2      = CHK_W'(est2) * CHK_W'(cpc_pkg::BRIGHT_LEVELS);
  // reciprocal estimate is at most one too high
  assign duty1_fix = (chk1 > CHK_W'(prod1)) ? est1 - 1'b1 : est1;
  assign duty2_fix = (chk2 > CHK_W'(prod2)) ? est2 - 1'b1 : est2;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      resp_idx          <= '0;
      led1_target       <= '0;
      led2_target       <= '0;
      main_level        <= '0;
      rgb_level         <= '0;
      side_level        <= '0;
      laser_state       <= 1'b0;
      aux_state         <= 1'b0;
      last_laser_button <= 1'b0;
      last_aux_button   <= 1'b0;
      motor1_state      <= cpc_pkg::MOTOR_BRAKE;
      motor2_state      <= cpc_pkg::MOTOR_BRAKE;
      latched_angle     <= '0;
      led1_duty         <= '0;
      led2_duty         <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!pkt_empty) begin
            led1_target     <= pkt.new_led1;
            led2_target     <= pkt.new_led2;
            if (aux_btn && !last_aux_button) aux_state <= !aux_state;
            if (laser_btn && !last_laser_button) laser_state <= !laser_state;
            last_aux_button   <= aux_btn;
            last_laser_button <= laser_btn;
            case (pkt.channel_byte)
              cpc_pkg::CHAN_MAIN: main_level <= cpc_pkg::adjust_level(main_level, pkt.button_byte);
              cpc_pkg::CHAN_RGB:  rgb_level  <= cpc_pkg::adjust_level(rgb_level, pkt.button_byte);
              cpc_pkg::CHAN_SIDE: side_level <= cpc_pkg::adjust_level(side_level, pkt.button_byte);
              default: ;
            endcase
            if (pkt.motor_byte[cpc_pkg::MOT1_OPEN]) motor1_state <= cpc_pkg::MOTOR_FORWARD;
            else if (pkt.motor_byte[cpc_pkg::MOT1_CLOSE]) motor1_state <= cpc_pkg::MOTOR_REVERSE;
            else motor1_state <= cpc_pkg::MOTOR_BRAKE;
            if (pkt.motor_byte[cpc_pkg::MOT2_LEFT]) motor2_state <= cpc_pkg::MOTOR_FORWARD;
            else if (pkt.motor_byte[cpc_pkg::MOT2_RIGHT]) motor2_state <= cpc_pkg::MOTOR_REVERSE;
            else motor2_state <= cpc_pkg::MOTOR_BRAKE;
            latched_angle <= pkt.angle;
            state         <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          state <= ST_FIX;
        end
        ST_FIX: begin
          led1_duty <= duty1_fix[7:0];
          led2_duty <= duty2_fix[7:0];
          resp_idx  <= '0;
          state     <= ST_SEND;
        end
        ST_SEND: begin
          if (out_pop) begin
            if (tx_last) begin
              state <= ST_IDLE;
            end else begin
              resp_idx <= resp_idx + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
    if (state == ST_MUL) begin
      prod1 <= cpc_pkg::PROD_W'(led1_target) * cpc_pkg::PROD_W'(main_level);
      prod2 <= cpc_pkg::PROD_W'(led2_target) * cpc_pkg::PROD_W'(main_level);
    end
    if (state == ST_DIV) begin
      est1 <= est1_full[cpc_pkg::RECIP_SHIFT +: cpc_pkg::PROD_W];
      est2 <= est2_full[cpc_pkg::RECIP_SHIFT +: cpc_pkg::PROD_W];
    end
  end

  always_comb begin
    case (resp_idx)
      cpc_pkg::RIDX_W'(cpc_pkg::RESP_STATUS):   tx_byte = {6'd0, aux_state, laser_state};
      cpc_pkg::RIDX_W'(cpc_pkg::RESP_RGB):      tx_byte = cpc_pkg::level_percent(rgb_level);
      cpc_pkg::RIDX_W'(cpc_pkg::RESP_MAIN):     tx_byte = cpc_pkg::level_percent(main_level);
      cpc_pkg::RIDX_W'(cpc_pkg::RESP_SIDE):     tx_byte = cpc_pkg::level_percent(side_level);
      cpc_pkg::RIDX_W'(cpc_pkg::RESP_ANGLE_HI): tx_byte = {{7{latched_angle[8]}}, latched_angle[8]};
      cpc_pkg::RIDX_W'(cpc_pkg::RESP_ANGLE_LO): tx_byte = latched_angle[7:0];
      default:                                  tx_byte = 8'd0;
    endcase
  end

  assign tx_last          = (resp_idx == cpc_pkg::RIDX_W'(cpc_pkg::RESPONSE_BYTES - 1));
  assign laser_enable     = laser_state;
  assign aux_enable       = aux_state;
  assign motor1_direction = motor1_state;
  assign motor2_direction = motor2_state;

endmodule

`default_nettype wire

// ===== sv/command_packet_controller.sv =====
`default_nettype none

// Command packet controller. Received bytes are taken one per cycle while full is low and
// framed into 32-byte command packets that open with three programmable header bytes; a
// completed packet goes into a two-entry packet queue, so framing of the next packet goes on
// while the previous response is still being read out. For each packet the back end takes
// the commands, works the LED duty arithmetic in order (product, reciprocal multiply,
// correction) and then offers the 64 response bytes, one per cycle as pop allows, with the
// status, level and angle fields at fixed positions and zero in the other bytes; full rises
// only while both queue entries wait.
// The motor duty register is accepted on the configuration port but drives no output.

`include "assert_macros.svh"

module command_packet_controller (
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_write,
  input  wire [1:0]        cfg_index,
  input  wire [7:0]        cfg_data,
  input  wire              push,
  output logic             full,
  input  wire [7:0]        rx_byte,
  input  wire signed [8:0] tilt_angle,
  output logic             empty,
  input  wire              pop,
  output logic [7:0]       tx_byte,
  output logic             tx_last,
  output logic [7:0]       led1_duty,
  output logic [7:0]       led2_duty,
  output logic             laser_enable,
  output logic             aux_enable,
  output logic [1:0]       motor1_direction,
  output logic [1:0]       motor2_direction
);

  cpc_pkg::header_cfg_t hdr;
  cpc_pkg::packet_t     front_pkt;
  cpc_pkg::packet_t     back_pkt;
  logic                 front_push;
  logic                 q_full;
  logic                 q_empty;
  logic                 back_pop;
  logic                 in_accept;

  assign in_accept = push && !full;
  assign full      = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr.header_first  <= cpc_pkg::HEADER_FIRST_RESET;
      hdr.header_second <= cpc_pkg::HEADER_SECOND_RESET;
      hdr.header_third  <= cpc_pkg::HEADER_THIRD_RESET;
    end else if (cfg_write) begin
      case (cpc_pkg::cfg_reg_t'(cfg_index))
        cpc_pkg::REG_HEADER_FIRST:  hdr.header_first  <= cfg_data;
        cpc_pkg::REG_HEADER_SECOND: hdr.header_second <= cfg_data;
        cpc_pkg::REG_HEADER_THIRD:  hdr.header_third  <= cfg_data;
        default: ;
      endcase
    end
  end

  cpc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .hdr        (hdr),
    .accept     (in_accept),
    .rx_byte    (rx_byte),
    .tilt_angle (tilt_angle),
    .pkt_push   (front_push),
    .pkt        (front_pkt)
  );

  cpc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (front_push),
    .push_pkt (front_pkt),
    .full     (q_full),
    .pop      (back_pop),
    .pop_pkt  (back_pkt),
    .empty    (q_empty)
  );

  cpc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .pkt              (back_pkt),
    .pkt_empty        (q_empty),
    .pkt_pop          (back_pop),
    .empty            (empty),
    .pop              (pop),
    .tx_byte          (tx_byte),
    .tx_last          (tx_last),
    .led1_duty        (led1_duty),
    .led2_duty        (led2_duty),
    .laser_enable     (laser_enable),
    .aux_enable       (aux_enable),
    .motor1_direction (motor1_direction),
    .motor2_direction (motor2_direction)
  );

  // a completed packet never meets a full queue
  `ASSERT_ALWAYS(a_push_not_full, clk, front_push |-> !q_full)
  // the response ends after its last byte transfer
  `ASSERT_RST(a_last_ends, clk, rst, (pop && !empty && tx_last) |=> empty)
  // duties hold through a response
  `ASSERT_RST(a_duty_hold, clk, rst, (!empty && !(pop && tx_last)) |=> (!empty && $stable(led1_duty) && $stable(led2_duty)))

endmodule

`default_nettype wire
